### src/crs_pkg.sv
// Shared types, constants and the character rank table for the card radix sorter.
`default_nettype none

package crs_pkg;

    localparam int SUIT_W       = 2;
    localparam int CHAR_W       = 64;
    localparam int CARD_W       = SUIT_W + CHAR_W;
    localparam int DIGIT_CFG_W  = 4;
    localparam int POS_W        = 3;
    localparam int KEY_W        = 4;
    localparam int RANK_BUCKETS = 11;

    localparam logic [KEY_W-1:0] RANK_OTHER = KEY_W'(10);

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic              load_wr;
        logic              clear_cnt;
        logic              rd_en;
        logic              rd_sel;      // 0: store a is the source, 1: store b
        logic              cnt_inc;
        logic              prefix_step;
        logic [KEY_W-1:0]  prefix_idx;
        logic              scatter_wr;
        logic              suit_key;
        logic [POS_W-1:0]  key_pos;
        logic              out_ld;
        logic              out_last;
        logic              out_ovf;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    // Rank order 4,5,6,7,Q,J,K,A,2,3; anything else sorts after all of them.
    function automatic logic [KEY_W-1:0] char_rank(input logic [7:0] c);
        logic [KEY_W-1:0] r;
        case (c)
            "4": r = KEY_W'(0);
            "5": r = KEY_W'(1);
            "6": r = KEY_W'(2);
            "7": r = KEY_W'(3);
            "Q": r = KEY_W'(4);
            "J": r = KEY_W'(5);
            "K": r = KEY_W'(6);
            "A": r = KEY_W'(7);
            "2": r = KEY_W'(8);
            "3": r = KEY_W'(9);
            default: r = RANK_OTHER;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/crs_datapath.sv
// Card stores, bucket counters, sort key logic and the output register.
`default_nettype none

module crs_datapath #(
    parameter int MAX_CARDS = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  crs_pkg::cmd_t                    cmd,
    input  wire [$clog2(MAX_CARDS)-1:0]      rd_addr,
    input  wire [$clog2(MAX_CARDS)-1:0]      wr_addr,
    input  wire [crs_pkg::SUIT_W-1:0]        in_suit,
    input  wire [crs_pkg::CHAR_W-1:0]        in_chars,
    input  wire                              m_ready,
    output logic                             m_valid,
    output logic [crs_pkg::SUIT_W-1:0]       m_suit,
    output logic [crs_pkg::CHAR_W-1:0]       m_chars,
    output logic                             m_last,
    output logic                             m_ovf,
    output crs_pkg::sts_t                    sts
);
    import crs_pkg::*;

    localparam int IDX_W = $clog2(MAX_CARDS);
    localparam int CNT_W = $clog2(MAX_CARDS + 1);

    logic [CARD_W-1:0] store_a [MAX_CARDS];
    logic [CARD_W-1:0] store_b [MAX_CARDS];

    logic [CARD_W-1:0] a_q_reg;
    logic [CARD_W-1:0] b_q_reg;
    logic [CARD_W-1:0] rd_card;

    logic [CNT_W-1:0]  bucket_reg [RANK_BUCKETS];
    logic [CNT_W-1:0]  acc_reg;

    logic [7:0]        char_byte [8];
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  scat_addr;

    logic              we_a;
    logic              we_b;
    logic [IDX_W-1:0]  addr_a;
    logic [CARD_W-1:0] data_a;

    logic                  m_valid_reg;
    logic [SUIT_W-1:0]     m_suit_reg;
    logic [CHAR_W-1:0]     m_chars_reg;
    logic                  m_last_reg;
    logic                  m_ovf_reg;

    assign rd_card = cmd.rd_sel ? b_q_reg : a_q_reg;

    // character 0 sits in the top byte
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            char_byte[i] = rd_card[SUIT_W + CHAR_W - 1 - 8 * i -: 8];
        end
    end

    assign key = cmd.suit_key ? KEY_W'(rd_card[SUIT_W-1:0])
                              : char_rank(char_byte[cmd.key_pos]);

    assign scat_addr = bucket_reg[key][IDX_W-1:0];

    // store a takes card loads and scatters from b; store b only scatters from a
    assign we_a   = cmd.load_wr | (cmd.scatter_wr & cmd.rd_sel);
    assign we_b   = cmd.scatter_wr & ~cmd.rd_sel;
    assign addr_a = cmd.load_wr ? wr_addr : scat_addr;
    assign data_a = cmd.load_wr ? {in_chars, in_suit} : rd_card;

    always_ff @(posedge aclk) begin
        if (we_a) begin
            store_a[addr_a] <= data_a;
        end
        if (we_b) begin
            store_b[scat_addr] <= rd_card;
        end
        if (cmd.rd_en) begin
            a_q_reg <= store_a[rd_addr];
            b_q_reg <= store_b[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_cnt) begin
            for (int i = 0; i < RANK_BUCKETS; i++) begin
                bucket_reg[i] <= '0;
            end
            acc_reg <= '0;
        end else if (cmd.prefix_step) begin
            // exclusive prefix: each bucket becomes its first destination slot
            bucket_reg[cmd.prefix_idx] <= acc_reg;
            acc_reg                    <= acc_reg + bucket_reg[cmd.prefix_idx];
        end else if (cmd.cnt_inc) begin
            bucket_reg[key] <= bucket_reg[key] + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            m_suit_reg  <= rd_card[SUIT_W-1:0];
            m_chars_reg <= rd_card[CARD_W-1:SUIT_W];
            m_last_reg  <= cmd.out_last;
            m_ovf_reg   <= cmd.out_ovf;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_suit       = m_suit_reg;
    assign m_chars      = m_chars_reg;
    assign m_last       = m_last_reg;
    assign m_ovf        = m_ovf_reg;
    assign sts.out_free = ~m_valid_reg | m_ready;

`ifndef SYNTHESIS
    a_no_load_during_scatter: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_wr && cmd.scatter_wr))
        else $error("card load collides with a scatter write");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready && !cmd.out_ld |=> m_valid_reg && $stable(m_chars_reg))
        else $error("stalled result changed");

    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> key <= RANK_OTHER)
        else $error("sort key out of bucket range");
`endif

endmodule

`default_nettype wire

### src/crs_ctrl.sv
// Sequencer for loading, counting-sort passes and emission of the card set.
`default_nettype none

module crs_ctrl #(
    parameter int MAX_CARDS  = 64,
    parameter int MAX_DIGITS = 8
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire [crs_pkg::DIGIT_CFG_W-1:0]      cfg_wr_data,
    input  wire                                 s_valid,
    input  wire                                 s_last,
    output logic                                s_ready,
    input  crs_pkg::sts_t                       sts,
    output crs_pkg::cmd_t                       cmd,
    output logic [$clog2(MAX_CARDS)-1:0]        rd_addr,
    output logic [$clog2(MAX_CARDS)-1:0]        wr_addr
);
    import crs_pkg::*;

    localparam int IDX_W = $clog2(MAX_CARDS);
    localparam int CNT_W = $clog2(MAX_CARDS + 1);

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_CLEAR     = 3'd1;
    localparam logic [2:0] S_COUNT     = 3'd2;
    localparam logic [2:0] S_PREFIX    = 3'd3;
    localparam logic [2:0] S_SCATTER   = 3'd4;
    localparam logic [2:0] S_EMIT_RD   = 3'd5;
    localparam logic [2:0] S_EMIT_WAIT = 3'd6;

    logic [2:0]             state_reg,     state_next;
    logic [CNT_W-1:0]       cnt_reg,       cnt_next;
    logic [CNT_W-1:0]       idx_reg,       idx_next;
    logic                   rd_vld_reg,    rd_vld_next;
    logic [KEY_W-1:0]       pfx_reg,       pfx_next;
    logic [POS_W-1:0]       pos_reg,       pos_next;
    logic                   suit_pass_reg, suit_pass_next;
    logic                   src_reg,       src_next;
    logic                   dropped_reg,   dropped_next;
    logic [DIGIT_CFG_W-1:0] digits_reg;

    logic [DIGIT_CFG_W-1:0] digits_eff;
    logic [DIGIT_CFG_W-1:0] digits_m1;
    logic [CNT_W-1:0]       idx_inc;
    logic                   more_rd;

    assign digits_eff = (digits_reg > DIGIT_CFG_W'(MAX_DIGITS)) ? DIGIT_CFG_W'(MAX_DIGITS)
                                                                : digits_reg;
    assign digits_m1  = digits_eff - DIGIT_CFG_W'(1);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign more_rd    = idx_reg < cnt_reg;
    assign rd_addr    = idx_reg[IDX_W-1:0];
    assign wr_addr    = cnt_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg <= DIGIT_CFG_W'(1);
        end else if (cfg_wr_en) begin
            digits_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        pfx_next       = pfx_reg;
        pos_next       = pos_reg;
        suit_pass_next = suit_pass_reg;
        src_next       = src_reg;
        dropped_next   = dropped_reg;
        s_ready        = 1'b0;

        cmd            = '0;
        cmd.rd_sel     = src_reg;
        cmd.suit_key   = suit_pass_reg;
        cmd.key_pos    = pos_reg;
        cmd.prefix_idx = pfx_reg;

        case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (cnt_reg < CNT_W'(MAX_CARDS)) begin
                        cmd.load_wr = 1'b1;
                        cnt_next    = cnt_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_last) begin
                        src_next       = 1'b0;
                        suit_pass_next = (digits_eff == '0);
                        pos_next       = digits_m1[POS_W-1:0];
                        state_next     = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                cmd.clear_cnt = 1'b1;
                idx_next      = '0;
                state_next    = S_COUNT;
            end
            S_COUNT, S_SCATTER: begin
                // read one card a cycle; the key acts on the read data in the next cycle
                cmd.rd_en   = more_rd;
                rd_vld_next = more_rd;
                if (more_rd) begin
                    idx_next = idx_inc;
                end
                cmd.cnt_inc    = rd_vld_reg;
                cmd.scatter_wr = rd_vld_reg && (state_reg == S_SCATTER);
                if (!more_rd && !rd_vld_reg) begin
                    if (state_reg == S_COUNT) begin
                        pfx_next   = '0;
                        state_next = S_PREFIX;
                    end else begin
                        src_next = ~src_reg;
                        if (suit_pass_reg) begin
                            idx_next   = '0;
                            state_next = S_EMIT_RD;
                        end else begin
                            if (pos_reg == '0) begin
                                suit_pass_next = 1'b1;
                            end else begin
                                pos_next = pos_reg - POS_W'(1);
                            end
                            state_next = S_CLEAR;
                        end
                    end
                end
            end
            S_PREFIX: begin
                cmd.prefix_step = 1'b1;
                if (pfx_reg == KEY_W'(RANK_BUCKETS - 1)) begin
                    idx_next   = '0;
                    state_next = S_SCATTER;
                end else begin
                    pfx_next = pfx_reg + KEY_W'(1);
                end
            end
            S_EMIT_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (sts.out_free) begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_last = (idx_inc == cnt_reg);
                    cmd.out_ovf  = dropped_reg;
                    if (idx_inc == cnt_reg) begin
                        cnt_next     = '0;
                        dropped_next = 1'b0;
                        state_next   = S_LOAD;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            pfx_reg       <= '0;
            pos_reg       <= '0;
            suit_pass_reg <= 1'b0;
            src_reg       <= 1'b0;
            dropped_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            pfx_reg       <= pfx_next;
            pos_reg       <= pos_next;
            suit_pass_reg <= suit_pass_next;
            src_reg       <= src_next;
            dropped_reg   <= dropped_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_CARDS))
        else $error("card count above capacity");

    a_out_ld_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> sts.out_free)
        else $error("result loaded over a waiting transfer");

    a_prefix_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PREFIX |-> !rd_vld_reg)
        else $error("read still in flight during prefix sum");

    a_set_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld && cmd.out_last |=> state_reg == S_LOAD && cnt_reg == '0 && !dropped_reg)
        else $error("set not closed after its last result");
`endif

endmodule

`default_nettype wire

### src/card_radix_sorter_core.sv
// Top level of the card radix sorter: stream ports, controller and datapath.
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tdata {value_chars, suit}, tlast = last card
//  m_axis   out  m_axis_tvalid/tready       tdata {value_chars, suit}, tlast, tuser = overflow
//  cfg      in   cfg_wr_en                  cfg_wr_data = digits_in_use
//
// Cards load at one per cycle. After the last card the block runs d+1 passes
// (d = digits in use, capped at MAX_DIGITS), each a clear, a count, a prefix sum
// and a scatter over the n cards; emission reads each card, then loads it into the output register.
// Synchronous active-low reset; the card stores need no clearing pass.
// s_axis_tready is low from the last card until its last result is in the output register.
`default_nettype none

module card_radix_sorter_core #(
    parameter int MAX_CARDS  = 64,
    parameter int MAX_DIGITS = 8
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_wr_en,
    input  wire [3:0]  cfg_wr_data,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [71:0] s_axis_tdata,   // [1:0] suit, [65:2] value_chars, [71:66] zero
    input  wire        s_axis_tlast,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [1:0] out_suit, [65:2] out_value_chars, [71:66] zero
    output logic       m_axis_tlast,
    output logic [0:0] m_axis_tuser    // [0] overflow
);
    import crs_pkg::*;

    localparam int IDX_W = $clog2(MAX_CARDS);

    cmd_t              cmd;
    sts_t              sts;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [SUIT_W-1:0] m_suit;
    logic [CHAR_W-1:0] m_chars;
    logic              m_ovf;

    crs_ctrl #(
        .MAX_CARDS  (MAX_CARDS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_axis_tvalid),
        .s_last      (s_axis_tlast),
        .s_ready     (s_axis_tready),
        .sts         (sts),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr)
    );

    crs_datapath #(
        .MAX_CARDS (MAX_CARDS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .in_suit  (s_axis_tdata[SUIT_W-1:0]),
        .in_chars (s_axis_tdata[CARD_W-1:SUIT_W]),
        .m_ready  (m_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_suit   (m_suit),
        .m_chars  (m_chars),
        .m_last   (m_axis_tlast),
        .m_ovf    (m_ovf),
        .sts      (sts)
    );

    assign m_axis_tdata = {6'b0, m_chars, m_suit};
    assign m_axis_tuser = m_ovf;

endmodule

`default_nettype wire

### bench/crs_checker.sv
// Card radix sorter scoreboard: mirrors each loaded card set, sorts it and checks the output stream.
module crs_checker (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_wr_en,
    input  wire [3:0]    cfg_wr_data,
    input  wire          s_axis_tvalid,
    input  wire          s_axis_tready,
    input  wire [71:0]   s_axis_tdata,   // [1:0] suit, [65:2] value_chars, [71:66] zero
    input  wire          s_axis_tlast,
    input  wire          m_axis_tvalid,
    input  wire          m_axis_tready,
    input  wire [71:0]   m_axis_tdata,   // [1:0] out_suit, [65:2] out_value_chars, [71:66] zero
    input  wire          m_axis_tlast,
    input  wire [0:0]    m_axis_tuser,   // [0] overflow
    output int unsigned  errors,
    output int unsigned  expected_left,
    output int unsigned  results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CARDS  = 64;
    localparam int MAX_DIGITS = 8;
    localparam int RANK_NONE  = 10;
    localparam int KEY_COUNT  = 11;
    // face order, lowest rank in the top byte
    localparam bit [79:0] RANK_ORDER = "4567QJKA23";

    typedef struct packed {
        bit [crs_pkg::SUIT_W-1:0] suit;
        bit [crs_pkg::CHAR_W-1:0] chars;
    } card_t;

    typedef struct packed {
        card_t card;
        bit    last;
        bit    dropped;
    } sorted_card_t;

    card_t        set_cards[$];
    sorted_card_t sorted_cards[$];
    bit           set_dropped;
    bit [3:0]     digits_cfg;

    // pos < 0 selects the suit; otherwise the rank of character pos (0 = top byte)
    function automatic int unsigned card_key(card_t c, int pos);
        int unsigned r;
        bit [7:0]    ch;
        if (pos < 0)
            return c.suit;
        ch = c.chars[63 - 8*pos -: 8];
        for (r = 0; r < 10; r++)
            if (RANK_ORDER[79 - 8*r -: 8] == ch)
                return r;
        return RANK_NONE;
    endfunction

    // LSD passes, last used character first, suit last; each pass is stable
    function automatic void sort_set(int digits);
        card_t src[$];
        card_t dst[$];
        int    pos;
        int    k;
        src = set_cards;
        for (pos = digits - 1; pos >= -1; pos--) begin
            dst = {};
            for (k = 0; k < KEY_COUNT; k++)
                foreach (src[i])
                    if (card_key(src[i], pos) == k)
                        dst.push_back(src[i]);
            src = dst;
        end
        set_cards = src;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        card_t        c;
        sorted_card_t want;
        int           n_digits;
        if (!aresetn) begin
            set_cards       = {};
            sorted_cards    = {};
            set_dropped     = 1'b0;
            digits_cfg      = 4'd1;
            errors          = 0;
            results_checked = 0;
        end else begin
            if (cfg_wr_en)
                digits_cfg = cfg_wr_data;

            if (m_axis_tvalid && m_axis_tready) begin
                results_checked++;
                if (sorted_cards.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = sorted_cards.pop_front();
                    compare_field("suit", want.card.suit, m_axis_tdata[1:0]);
                    compare_field("value_chars", want.card.chars, m_axis_tdata[65:2]);
                    compare_field("tlast", want.last, m_axis_tlast);
                    compare_field("overflow", want.dropped, m_axis_tuser[0]);
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                c.suit  = s_axis_tdata[1:0];
                c.chars = s_axis_tdata[65:2];
                if (set_cards.size() < MAX_CARDS)
                    set_cards.push_back(c);
                else
                    set_dropped = 1'b1;
                if (s_axis_tlast) begin
                    n_digits = (digits_cfg > MAX_DIGITS) ? MAX_DIGITS : int'(digits_cfg);
                    sort_set(n_digits);
                    foreach (set_cards[i]) begin
                        want.card    = set_cards[i];
                        want.last    = (i == set_cards.size() - 1);
                        want.dropped = set_dropped;
                        sorted_cards.push_back(want);
                    end
                    set_cards   = {};
                    set_dropped = 1'b0;
                end
            end
        end
        expected_left <= sorted_cards.size();
    end

endmodule

### bench/tb.sv
// Card radix sorter testbench top: clock, reset, card and config stimulus, output stalls, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CARDS    = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_CARDS = 480;
    localparam int HOLD_SET     = 6;     // receiver holds off while this set drains
    localparam int HOLD_CYCLES  = 400;
    localparam bit [79:0] CARD_FACES = "4567QJKA23";

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [3:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    int unsigned errors;
    int unsigned expected_left;
    int unsigned results_checked;
    int unsigned cards_sent;
    int unsigned sets_sent;
    int unsigned overflow_sets;
    int unsigned sets_out;
    bit          tx_quiet;
    bit          rx_quiet;

    card_radix_sorter_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    crs_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("card_radix_sorter_core test failed");
        $finish;
    end

    task automatic send_card(input bit [1:0] suit, input bit [63:0] chars, input bit last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata  <= {6'b0, chars, suit};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        cards_sent++;
        if (last)
            sets_sent++;
    endtask

    // only called right after a last-card transfer, so the sort is under way
    task automatic write_digits(input bit [3:0] digits);
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (4) @(posedge aclk);
        cfg_wr_data <= digits;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic bit [3:0] pick_digits();
        case ($urandom_range(0, 5))
            0: return 4'd0;
            1: return 4'd15;
            2: return 4'd8;
            3: return 4'd1;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    // mostly face characters so that keys tie often; sometimes raw bits
    function automatic bit [63:0] pick_chars();
        bit [63:0] v;
        int        r;
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom};
        for (int b = 0; b < 8; b++) begin
            r = $urandom_range(0, 9);
            if (r < 9)
                v[8*b +: 8] = CARD_FACES[8*$urandom_range(0, 9) +: 8];
            else
                v[8*b +: 8] = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    // output side: random stalls, one long hold-off while the input is blocked
    initial begin
        int stall;
        bit held;
        m_axis_tready <= 1'b0;
        held     = 1'b0;
        rx_quiet = 1'b0;
        sets_out = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held && sets_out == HOLD_SET) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                do @(posedge aclk); while (!m_axis_tvalid);
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = rx_quiet ? 0 : $urandom_range(0, 15);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            if (m_axis_tlast)
                sets_out++;
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
        end
    end

    initial begin
        int unsigned set_idx;
        int unsigned set_size;
        int unsigned directed_cards;
        int          r;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 4'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        cards_sent    = 0;
        sets_sent     = 0;
        overflow_sets = 0;
        tx_quiet      = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lone card under the reset digit count
        send_card(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

        // full-width keys: every face, foreign bytes, ties broken by suit
        write_digits(4'd8);
        send_card(2'd0, "4567QJKA", 1'b0);
        send_card(2'd1, "23456789", 1'b0);
        send_card(2'd2, "QQQQQQQQ", 1'b0);
        send_card(2'd3, "AAAAAAA3", 1'b0);
        send_card(2'd0, "AAAAAAA2", 1'b0);
        send_card(2'd1, "JK7Q5A4Z", 1'b0);
        send_card(2'd2, "JK7Q5A4Z", 1'b0);
        send_card(2'd3, 64'h0, 1'b0);
        send_card(2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_card(2'd1, "3       ", 1'b0);
        send_card(2'd2, "K", 1'b1);

        // no character pass: suit alone orders the set
        write_digits(4'd0);
        send_card(2'd3, "44444444", 1'b0);
        send_card(2'd2, "33333333", 1'b0);
        send_card(2'd1, "AAAAAAAA", 1'b0);
        send_card(2'd0, "QQQQQQQQ", 1'b1);

        // digit count above the cap
        write_digits(4'd15);
        for (int i = 0; i < 5; i++)
            send_card(2'($urandom_range(0, 3)), pick_chars(), i == 4);

        directed_cards = cards_sent;
        set_idx = 4;
        while (cards_sent < directed_cards + RANDOM_CARDS) begin
            if (set_idx != HOLD_SET + 1 && $urandom_range(0, 1) == 1)
                write_digits(pick_digits());
            r = $urandom_range(0, 19);
            if (set_idx == HOLD_SET || r == 0)
                set_size = MAX_CARDS;
            else if (r == 1)
                set_size = MAX_CARDS + 1;      // last card arrives with the store full
            else if (r == 2)
                set_size = $urandom_range(MAX_CARDS + 2, MAX_CARDS + 16);
            else
                set_size = $urandom_range(1, 12);
            if (set_size > MAX_CARDS)
                overflow_sets++;
            tx_quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_size; i++)
                send_card(2'($urandom_range(0, 3)), pick_chars(), i == set_size - 1);
            set_idx++;
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (64) @(posedge aclk);

        $display("%0d cards in %0d sets (%0d over capacity) sorted, %0d output transfers checked",
                 cards_sent, sets_sent, overflow_sets, results_checked);
        if (errors == 0)
            $display("card_radix_sorter_core test passed");
        else
            $display("card_radix_sorter_core test failed");
        $finish;
    end

endmodule
